>>> rtl/mre_pkg.sv
`default_nettype none

package mre_pkg;

  // field widths
  localparam int BTN_W   = 3;
  localparam int MOD_W   = 3;
  localparam int POS_W   = 12;
  localparam int BYTE_W  = 8;
  localparam int CB_W    = 7;
  localparam int COORD_W = 14;   // one-based coordinate, up to four decimal digits
  localparam int POW_W   = 2;    // index of the current power of ten
  localparam int DIG_W   = 4;
  localparam int IN_W    = BTN_W + 1 + 1 + MOD_W + POS_W + POS_W;

  localparam int unsigned DEFAULT_MAX_COORD = 4095;
  localparam int unsigned LEGACY_LIMIT      = 223;

  // button codes on the input
  localparam logic [BTN_W-1:0] BTN_NONE     = 3'd0;
  localparam logic [BTN_W-1:0] BTN_LEFT     = 3'd1;
  localparam logic [BTN_W-1:0] BTN_MIDDLE   = 3'd2;
  localparam logic [BTN_W-1:0] BTN_RIGHT    = 3'd3;
  localparam logic [BTN_W-1:0] BTN_SC_UP    = 3'd4;
  localparam logic [BTN_W-1:0] BTN_SC_DN    = 3'd5;
  localparam logic [BTN_W-1:0] BTN_OTHER_LO = 3'd6;
  localparam logic [BTN_W-1:0] BTN_OTHER_HI = 3'd7;

  // report button byte codes
  localparam logic [CB_W-1:0] CB_MOTION_NONE = 7'd35;
  localparam logic [CB_W-1:0] CB_MOTION_BASE = 7'd32;
  localparam logic [CB_W-1:0] CB_SCROLL_UP   = 7'd64;
  localparam logic [CB_W-1:0] CB_SCROLL_DN   = 7'd65;
  localparam logic [CB_W-1:0] CB_LEGACY_REL  = 7'd3;

  // characters
  localparam logic [BYTE_W-1:0] CH_ESC    = 8'd27;
  localparam logic [BYTE_W-1:0] CH_BRACK  = 8'h5B;  // [
  localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;  // <
  localparam logic [BYTE_W-1:0] CH_UPPERM = 8'h4D;  // M
  localparam logic [BYTE_W-1:0] CH_LOWERM = 8'h6D;  // m
  localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;  // ;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;  // 0
  localparam logic [BYTE_W-1:0] CH_OFFSET = 8'd32;

  typedef enum logic [3:0] {
    PH_ESC,
    PH_BRK,
    PH_LEAD,
    PH_CB,
    PH_SEP1,
    PH_X,
    PH_SEP2,
    PH_Y,
    PH_FIN
  } phase_t;

  // one decoded event, ready to serialize
  typedef struct packed {
    logic               sgr;
    logic               upper;
    logic [CB_W-1:0]    cb;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [POW_W-1:0]   cb_pow;
    logic [POW_W-1:0]   x_pow;
    logic [POW_W-1:0]   y_pow;
  } event_t;

  typedef struct packed {
    logic [DIG_W-1:0]   digit;
    logic [COORD_W-1:0] rem;
  } digit_t;

  function automatic logic [COORD_W-1:0] pow10(input logic [POW_W-1:0] p);
    logic [COORD_W-1:0] d;
    unique case (p)
      2'd3:    d = COORD_W'(1000);
      2'd2:    d = COORD_W'(100);
      2'd1:    d = COORD_W'(10);
      default: d = COORD_W'(1);
    endcase
    return d;
  endfunction

  // position of the leading decimal digit
  function automatic logic [POW_W-1:0] lead_pow(input logic [COORD_W-1:0] v);
    logic [POW_W-1:0] p;
    if (v >= COORD_W'(1000)) p = 2'd3;
    else if (v >= COORD_W'(100)) p = 2'd2;
    else if (v >= COORD_W'(10)) p = 2'd1;
    else p = 2'd0;
    return p;
  endfunction

  // one decimal digit at power p, by parallel compares against its multiples
  function automatic digit_t digit_step(input logic [COORD_W-1:0] v,
                                        input logic [POW_W-1:0] p);
    digit_t             r;
    logic [COORD_W-1:0] lim;
    r.digit = '0;
    r.rem   = v;
    for (int k = 1; k <= 9; k++) begin
      unique case (p)
        2'd3:    lim = COORD_W'(k * 1000);
        2'd2:    lim = COORD_W'(k * 100);
        2'd1:    lim = COORD_W'(k * 10);
        default: lim = COORD_W'(k);
      endcase
      if (v >= lim) begin
        r.digit = DIG_W'(k);
        r.rem   = v - lim;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mouse_report_encoder.sv
`default_nettype none

// channel  | dir | beat content                                          | handshake
// ---------+-----+-------------------------------------------------------+--------------------
// in_      | in  | one mouse event in in_tdata                           | in_tvalid/in_tready
// out_     | out | one report byte in out_tdata, tlast on its final byte | out_tvalid/out_tready
// cfg_     | in  | sgr_mode in cfg_wr_data                               | cfg_wr_en, no wait
//
// a report leaves at one byte per cycle while out_tready is high: six bytes for a legacy
// report, 9 to 16 for sgr; the one-byte output register sets that rate
// an accepted event is decoded into a holding register while the previous report is still
// going out, so the next report starts right behind the last byte of the one before
// dropped events never reach the holding register and produce no beats
// rst_n is synchronous, active low, and clears sgr_mode to legacy
// a stall on out_tready freezes the serializer; in_tready falls once the holding register is full

module mouse_report_encoder #(
  parameter int unsigned MAX_COORD = mre_pkg::DEFAULT_MAX_COORD
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // button[2:0], is_motion[3], is_pressed[4], mod_bits[7:5], column[19:8], row[31:20]
  input  wire logic [mre_pkg::IN_W-1:0]  in_tdata,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // out_byte[7:0]
  output logic [mre_pkg::BYTE_W-1:0]     out_tdata,
  output logic                           out_tlast,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  input  wire logic                      cfg_wr_en,
  input  wire logic                      cfg_wr_data
);

  import mre_pkg::*;

  localparam logic [COORD_W-1:0] MaxCoord = COORD_W'(MAX_COORD);

  // configuration register
  logic cfg_sgr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sgr_r <= 1'b0;
    end else if (cfg_wr_en) begin
      cfg_sgr_r <= cfg_wr_data;
    end
  end

  // input field split
  logic [BTN_W-1:0] in_btn;
  logic             in_motion;
  logic             in_pressed;
  logic [MOD_W-1:0] in_mods;
  logic [POS_W-1:0] in_col;
  logic [POS_W-1:0] in_row;

  assign in_btn     = in_tdata[2:0];
  assign in_motion  = in_tdata[3];
  assign in_pressed = in_tdata[4];
  assign in_mods    = in_tdata[7:5];
  assign in_col     = in_tdata[19:8];
  assign in_row     = in_tdata[31:20];

  // event decode, straight off the input beat
  logic               dec_keep;
  logic [CB_W-1:0]    dec_cb_base;
  logic [COORD_W-1:0] dec_col_c;
  logic [COORD_W-1:0] dec_row_c;
  event_t             dec_ev;
  logic               btn_lmr;

  assign btn_lmr = (in_btn == BTN_LEFT) || (in_btn == BTN_MIDDLE) || (in_btn == BTN_RIGHT);

  always_comb begin
    dec_keep    = 1'b1;
    dec_cb_base = '0;
    if (in_motion) begin
      if (in_btn == BTN_NONE) begin
        dec_cb_base = CB_MOTION_NONE;
      end else if (btn_lmr) begin
        dec_cb_base = CB_MOTION_BASE + CB_W'(in_btn) - CB_W'(1);
      end else begin
        dec_keep = 1'b0;
      end
    end else if (in_btn == BTN_SC_UP) begin
      dec_cb_base = CB_SCROLL_UP;
    end else if (in_btn == BTN_SC_DN) begin
      dec_cb_base = CB_SCROLL_DN;
    end else if (!in_pressed && !cfg_sgr_r) begin
      dec_cb_base = CB_LEGACY_REL;
    end else if (btn_lmr) begin
      dec_cb_base = CB_W'(in_btn) - CB_W'(1);
    end else begin
      dec_keep = 1'b0;
    end

    // clamp, then one-based
    dec_col_c = (COORD_W'(in_col) > MaxCoord) ? MaxCoord : COORD_W'(in_col);
    dec_row_c = (COORD_W'(in_row) > MaxCoord) ? MaxCoord : COORD_W'(in_row);

    dec_ev.sgr    = cfg_sgr_r;
    dec_ev.upper  = in_pressed || in_motion;
    dec_ev.cb     = dec_cb_base | {2'b00, in_mods, 2'b00};
    dec_ev.cx     = dec_col_c + COORD_W'(1);
    dec_ev.cy     = dec_row_c + COORD_W'(1);
    dec_ev.cb_pow = lead_pow(COORD_W'(dec_ev.cb));
    dec_ev.x_pow  = lead_pow(dec_ev.cx);
    dec_ev.y_pow  = lead_pow(dec_ev.cy);

    // legacy report cannot carry a coordinate past the printable range
    if (!cfg_sgr_r && ((dec_ev.cx > COORD_W'(LEGACY_LIMIT)) ||
                       (dec_ev.cy > COORD_W'(LEGACY_LIMIT)))) begin
      dec_keep = 1'b0;
    end
  end

  // holding register: next event waits here while a report goes out
  logic   d_valid_r;
  logic   d_valid_nxt;
  event_t d_ev_r;
  logic   in_acc;
  logic   s_take;

  assign in_tready = !d_valid_r || s_take;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    d_valid_nxt = d_valid_r;
    if (s_take) begin
      d_valid_nxt = 1'b0;
    end
    if (in_acc && dec_keep) begin
      d_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else begin
      d_valid_r <= d_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && dec_keep) begin
      d_ev_r <= dec_ev;
    end
  end

  // serializer
  logic               s_busy_r;
  logic               s_busy_nxt;
  phase_t             phase_r;
  phase_t             phase_nxt;
  event_t             s_ev_r;
  event_t             s_ev_nxt;
  logic [COORD_W-1:0] num_r;
  logic [COORD_W-1:0] num_nxt;
  logic [POW_W-1:0]   pow_r;
  logic [POW_W-1:0]   pow_nxt;
  logic               step;
  logic               num_done;
  digit_t             dig;
  logic [BYTE_W-1:0]  dig_char;
  logic [BYTE_W-1:0]  byte_c;
  logic               last_c;
  logic               out_tvalid_r;
  logic               out_tvalid_nxt;
  logic [BYTE_W-1:0]  out_tdata_r;
  logic               out_tlast_r;

  assign step     = s_busy_r && (!out_tvalid_r || out_tready);
  assign num_done = (pow_r == '0);
  assign dig      = digit_step(num_r, pow_r);
  assign dig_char = CH_ZERO + BYTE_W'(dig.digit);
  assign s_take   = d_valid_r && (!s_busy_r || (step && last_c));

  // byte for the current phase
  always_comb begin
    byte_c = '0;
    last_c = 1'b0;
    unique case (phase_r)
      PH_ESC:  byte_c = CH_ESC;
      PH_BRK:  byte_c = CH_BRACK;
      PH_LEAD: byte_c = s_ev_r.sgr ? CH_LT : CH_UPPERM;
      PH_CB:   byte_c = s_ev_r.sgr ? dig_char : (BYTE_W'(s_ev_r.cb) + CH_OFFSET);
      PH_SEP1: byte_c = CH_SEMI;
      PH_X:    byte_c = s_ev_r.sgr ? dig_char : (s_ev_r.cx[BYTE_W-1:0] + CH_OFFSET);
      PH_SEP2: byte_c = CH_SEMI;
      PH_Y: begin
        byte_c = s_ev_r.sgr ? dig_char : (s_ev_r.cy[BYTE_W-1:0] + CH_OFFSET);
        last_c = !s_ev_r.sgr;
      end
      PH_FIN: begin
        byte_c = s_ev_r.upper ? CH_UPPERM : CH_LOWERM;
        last_c = 1'b1;
      end
      default: begin
        byte_c = '0;
        last_c = 1'b1;
      end
    endcase
  end

  // phase sequencing, one digit per step inside a number
  always_comb begin
    s_busy_nxt = s_busy_r;
    phase_nxt  = phase_r;
    s_ev_nxt   = s_ev_r;
    num_nxt    = num_r;
    pow_nxt    = pow_r;
    if (step) begin
      unique case (phase_r)
        PH_ESC:  phase_nxt = PH_BRK;
        PH_BRK:  phase_nxt = PH_LEAD;
        PH_LEAD: begin
          phase_nxt = PH_CB;
          num_nxt   = COORD_W'(s_ev_r.cb);
          pow_nxt   = s_ev_r.cb_pow;
        end
        PH_CB: begin
          if (!s_ev_r.sgr) begin
            phase_nxt = PH_X;
          end else if (num_done) begin
            phase_nxt = PH_SEP1;
          end else begin
            num_nxt = dig.rem;
            pow_nxt = pow_r - POW_W'(1);
          end
        end
        PH_SEP1: begin
          phase_nxt = PH_X;
          num_nxt   = s_ev_r.cx;
          pow_nxt   = s_ev_r.x_pow;
        end
        PH_X: begin
          if (!s_ev_r.sgr) begin
            phase_nxt = PH_Y;
          end else if (num_done) begin
            phase_nxt = PH_SEP2;
          end else begin
            num_nxt = dig.rem;
            pow_nxt = pow_r - POW_W'(1);
          end
        end
        PH_SEP2: begin
          phase_nxt = PH_Y;
          num_nxt   = s_ev_r.cy;
          pow_nxt   = s_ev_r.y_pow;
        end
        PH_Y: begin
          if (!s_ev_r.sgr) begin
            s_busy_nxt = 1'b0;
          end else if (num_done) begin
            phase_nxt = PH_FIN;
          end else begin
            num_nxt = dig.rem;
            pow_nxt = pow_r - POW_W'(1);
          end
        end
        PH_FIN:  s_busy_nxt = 1'b0;
        default: s_busy_nxt = 1'b0;
      endcase
    end
    // start the waiting event right behind the last byte
    if (s_take) begin
      s_busy_nxt = 1'b1;
      phase_nxt  = PH_ESC;
      s_ev_nxt   = d_ev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_busy_r <= 1'b0;
      phase_r  <= PH_ESC;
    end else begin
      s_busy_r <= s_busy_nxt;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_ev_r <= s_ev_nxt;
    num_r  <= num_nxt;
    pow_r  <= pow_nxt;
  end

  // output register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (step) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_tdata_r <= byte_c;
      out_tlast_r <= last_c;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef SYNTHESIS
  // serializer only goes idle after handing over a final byte
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!s_busy_r && out_tvalid_r) |-> out_tlast_r)
    else $error("serializer idle with a non-final byte pending");

  // legacy reports have no separators and no final character
  a_legacy_phases: assert property (@(posedge clk) disable iff (!rst_n)
    (s_busy_r && !s_ev_r.sgr) |->
      (phase_r != PH_SEP1 && phase_r != PH_SEP2 && phase_r != PH_FIN))
    else $error("legacy report entered an sgr-only phase");

  // the running number never has more digits than the power index allows
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (s_busy_r && s_ev_r.sgr && (phase_r == PH_CB || phase_r == PH_X || phase_r == PH_Y)) |->
      ({4'b0000, num_r} < (18'd10 * {4'b0000, pow10(pow_r)})))
    else $error("decimal digit out of range");
`endif

endmodule

`default_nettype wire
